### rtl/adpcm_pkg.sv
// types, constants and codes shared by the adaptive dpcm residual block
package adpcm_pkg;

   // line buffer depth and derived widths
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

   // register field widths
   localparam int MODE_W    = 2;
   localparam int IMG_W_W   = 12;
   localparam int CSR_W     = 12;
   localparam int PIX_W     = 8;
   localparam int RES_W     = 10;

   // width compares run at the wider of the field and the counter
   localparam int CMP_W     = (CNT_W > IMG_W_W) ? CNT_W : IMG_W_W;

   localparam logic [RES_W-1:0] RESIDUAL_OFFSET = RES_W'(128);

   typedef enum logic [MODE_W-1:0] {
      MODE_LEFT     = 2'd0,
      MODE_ABOVE    = 2'd1,
      MODE_ADAPTIVE = 2'd2,
      MODE_ADAPT_X  = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_PREDICT_MODE = 1'b0,
      CSR_IMAGE_WIDTH  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] residual;
      logic                    passed_raw;
   } rsp_type;

   // line buffer access from the accept stage
   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] wdata;
   } lb_req_type;

endpackage

### rtl/adpcm_line_buf.sv
// previous-row line buffer: read-first synchronous ram with a registered read
module adpcm_line_buf (
   input  logic                     clock,
   input  adpcm_pkg::lb_req_type    lb_req,
   output logic [adpcm_pkg::PIX_W-1:0] rd_data
);
   import adpcm_pkg::*;

   logic [PIX_W-1:0] mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd_data_ff;

   // read returns the old entry when the same entry is written in the same cycle
   always_ff @(posedge clock) begin
      if (lb_req.en) begin
         rd_data_ff          <= mem[lb_req.addr];
         mem[lb_req.addr]    <= lb_req.wdata;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/adaptive_dpcm_residual.sv
// top level of the adaptive dpcm residual generator
//
// Takes 8-bit grey pixels in raster order and gives one residual beat per
// pixel beat: pixel - prediction + 128 as a signed 10-bit value, or the raw
// pixel with passed_raw set where no prediction applies (column 0 in left
// mode, the first row in above mode, both in adaptive mode; mode 3 acts as
// adaptive). One pixel is taken every clock while rsp_ready is high; a result
// is presented once its pixel has passed stage 1 and the output register.
// Stage 1 is needed by the line buffer: it has a single port with a
// registered read, so the pixel above is fetched and the new pixel written in
// the accept cycle, and the prediction is formed in stage 1 from that read,
// then held in the output register. The line buffer has no reset and no
// clearing pass; the first row of every image is never predicted from it.
// image_width of 0 acts as 1 and values above 2048 act as 2048. Configuration
// is to be written only while the block idles; the block does not enforce it.
module adaptive_dpcm_residual (
   input  logic                           clock,
   input  logic                           reset,
   // pixel channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  adpcm_pkg::req_type             req_data,
   // residual channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output adpcm_pkg::rsp_type             rsp_data,
   // register writes
   input  logic                           csr_we,
   input  adpcm_pkg::csr_idx_type         csr_index,
   input  logic [adpcm_pkg::CSR_W-1:0]    csr_wdata
);
   import adpcm_pkg::*;

   // config registers
   mode_type             mode_ff;
   logic [IMG_W_W-1:0]   img_width_ff;

   // raster position, updated at accept
   logic [COL_W-1:0]     col_count_ff, col_count_in;
   logic                 first_row_ff, first_row_in;

   // stage 1: pixel waiting for its above neighbor from the buffer
   logic                 s1_valid_ff;
   logic [PIX_W-1:0]     s1_pixel_ff;
   logic                 s1_col_zero_ff;
   logic                 s1_first_row_ff;

   // neighbors from the previous pixel that left stage 1
   logic [PIX_W-1:0]     left_ff;
   logic [PIX_W-1:0]     upleft_ff;

   // output register
   logic                 out_valid_ff;
   rsp_type              out_data_ff, out_data_in;

   logic                 req_acc, out_free, s1_move;
   logic [COL_W-1:0]     cur_col;
   logic                 cur_first_row;
   logic [CMP_W-1:0]     eff_width, next_col;
   logic [PIX_W-1:0]     up_pixel;
   logic [PIX_W-1:0]     diff_lu, diff_uu, pred;
   logic                 raw, use_up;
   lb_req_type           lb_req;

   // ---------------------------------------------------------------- handshake
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_acc   = req_valid && req_ready;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ADAPTIVE;
         img_width_ff <= IMG_W_W'(MAX_WIDTH);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PREDICT_MODE: mode_ff      <= mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_IMAGE_WIDTH:  img_width_ff <= csr_wdata[IMG_W_W-1:0];
         endcase
      end
   end

   // zero width acts as one, oversize width saturates at the buffer depth
   always_comb begin
      eff_width = CMP_W'(img_width_ff);
      if (img_width_ff == '0) begin
         eff_width = CMP_W'(1);
      end else if (CMP_W'(img_width_ff) > CMP_W'(MAX_WIDTH)) begin
         eff_width = CMP_W'(MAX_WIDTH);
      end
   end

   // ---------------------------------------------------------------- raster position
   always_comb begin
      cur_col       = req_data.frame_start ? '0 : col_count_ff;
      cur_first_row = req_data.frame_start ? 1'b1 : first_row_ff;
      next_col      = CMP_W'(cur_col) + CMP_W'(1);
      col_count_in  = col_count_ff;
      first_row_in  = first_row_ff;
      if (req_acc) begin
         if (next_col >= eff_width) begin
            col_count_in = '0;
            first_row_in = 1'b0;
         end else begin
            col_count_in = next_col[COL_W-1:0];
            first_row_in = cur_first_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         first_row_ff <= 1'b1;
      end else begin
         col_count_ff <= col_count_in;
         first_row_ff <= first_row_in;
      end
   end

   // ---------------------------------------------------------------- line buffer
   // fetch the pixel above and store the new one at the same column
   assign lb_req.en    = req_acc;
   assign lb_req.addr  = cur_col;
   assign lb_req.wdata = req_data.pixel;

   adpcm_line_buf u_line_buf (
      .clock   (clock),
      .lb_req  (lb_req),
      .rd_data (up_pixel)
   );

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_pixel_ff     <= req_data.pixel;
         s1_col_zero_ff  <= (cur_col == '0);
         s1_first_row_ff <= cur_first_row;
      end
   end

   // left and up-left follow the pixel stream in order
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         upleft_ff <= '0;
      end else if (s1_move) begin
         left_ff   <= s1_pixel_ff;
         upleft_ff <= up_pixel;
      end
   end

   // gradient test and residual
   always_comb begin
      diff_lu = (left_ff > upleft_ff) ? (left_ff - upleft_ff) : (upleft_ff - left_ff);
      diff_uu = (upleft_ff > up_pixel) ? (upleft_ff - up_pixel) : (up_pixel - upleft_ff);
      unique case (mode_ff)
         MODE_LEFT: begin
            raw    = s1_col_zero_ff;
            use_up = 1'b0;
         end
         MODE_ABOVE: begin
            raw    = s1_first_row_ff;
            use_up = 1'b1;
         end
         MODE_ADAPTIVE, MODE_ADAPT_X: begin
            raw    = s1_first_row_ff || s1_col_zero_ff;
            use_up = (diff_lu < diff_uu);
         end
      endcase
      pred = use_up ? up_pixel : left_ff;
      out_data_in.passed_raw = raw;
      if (raw) begin
         out_data_in.residual = RES_W'(s1_pixel_ff);
      end else begin
         out_data_in.residual = RES_W'(s1_pixel_ff) - RES_W'(pred) + RESIDUAL_OFFSET;
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---------------------------------------------------------------- checks
   // a frame start always lands in stage 1 as column 0 of a first row
   a_frame_start_pos: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.frame_start |=> s1_valid_ff && s1_col_zero_ff && s1_first_row_ff)
      else $error("frame start did not reach stage 1 at column 0, first row");

   // a pixel leaving stage 1 becomes a pending result
   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid)
      else $error("stage 1 pixel lost on its way to the output register");

   // a stalled stage 1 keeps the buffer read data it depends on
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(up_pixel) && $stable(s1_pixel_ff))
      else $error("stalled stage 1 changed");

   // a predicted residual stays within its range
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.passed_raw |->
         (rsp_data.residual >= -10'sd127) && (rsp_data.residual <= 10'sd383))
      else $error("residual out of range");

endmodule
